### hdl/coordinate_keyed_hash_map_macros.svh
// assertion macros for the coordinate keyed hash map
`ifndef COORDINATE_KEYED_HASH_MAP_MACROS_SVH
`define COORDINATE_KEYED_HASH_MAP_MACROS_SVH

// same-cycle implication
`define CKHM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CKHM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ckhm_pkg.sv
// ----------------------------------------------------------------------------
// ckhm_pkg
// shared types and constants of the coordinate keyed hash map
// ----------------------------------------------------------------------------
package ckhm_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WLOAD,
    S_WCHK,
    S_WRD,
    S_WCMP,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_NEW,
    S_LINK,
    S_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    H_IDLE,
    H_MIX_X,
    H_MIX_Y,
    H_MOD,
    H_RED,
    H_DONE
  } hash_state_e;

  // one fnv step: xor in the sign-extended coordinate, multiply by 2^40 + 0x1b3
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [31:0] k);
    logic [63:0] x;
    x = h ^ {{32{k[31]}}, k};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

### hdl/ckhm_hash.sv
// ----------------------------------------------------------------------------
// ckhm_hash
// 64-bit fnv mix of the key pair; bucket = low bits if BUCKETS is 2^n, else
// a remainder taken 16 bits at a time by reciprocal multiply, one correction
// ----------------------------------------------------------------------------
module ckhm_hash #(
  parameter int BUCKETS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [31:0]                 key_x_i,
  input  logic [31:0]                 key_y_i,
  output logic                        done_o,
  output logic [$clog2(BUCKETS)-1:0]  bucket_o
);

  localparam int          BW    = $clog2(BUCKETS);
  localparam bit          POW2  = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam int          SH    = 32 + BW;
  localparam logic [32:0] RECIP = 33'((64'd1 << SH) / 64'(BUCKETS));

  ckhm_pkg::hash_state_e state_q, state_d;

  logic [63:0]   h_q, h_d;
  logic [31:0]   ky_q, ky_d;
  logic [31:0]   kx_q, kx_d;
  logic [BW-1:0] rem_q, rem_d;
  logic [15:0]   quo_q, quo_d;
  logic [1:0]    dig_q, dig_d;
  logic [31:0]   part;
  logic [64:0]   prod;
  logic [32:0]   diff;
  logic [16:0]   diff_lo;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ckhm_pkg::H_IDLE:  if (go_i) state_d = ckhm_pkg::H_MIX_X;
      ckhm_pkg::H_MIX_X: state_d = ckhm_pkg::H_MIX_Y;
      ckhm_pkg::H_MIX_Y: state_d = POW2 ? ckhm_pkg::H_DONE : ckhm_pkg::H_MOD;
      ckhm_pkg::H_MOD:   state_d = ckhm_pkg::H_RED;
      ckhm_pkg::H_RED:   state_d = (dig_q == 2'd3) ? ckhm_pkg::H_DONE : ckhm_pkg::H_MOD;
      ckhm_pkg::H_DONE:  state_d = ckhm_pkg::H_IDLE;
      default:           state_d = ckhm_pkg::H_IDLE;
    endcase
  end

  // remainder digit: (rem * 2^16 + next 16 hash bits) mod BUCKETS
  always_comb begin
    part    = {16'(rem_q), h_q[63:48]};
    prod    = 65'(part) * 65'(RECIP);
    diff    = {1'b0, part} - 33'(quo_q) * 33'(BUCKETS);
    diff_lo = diff[16:0];
  end

  always_comb begin
    h_d   = h_q;
    kx_d  = kx_q;
    ky_d  = ky_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dig_d = dig_q;
    case (state_q)
      ckhm_pkg::H_IDLE: begin
        if (go_i) begin
          h_d  = ckhm_pkg::FNV_BASIS;
          kx_d = key_x_i;
          ky_d = key_y_i;
        end
      end
      ckhm_pkg::H_MIX_X: h_d = ckhm_pkg::fnv_mix(h_q, kx_q);
      ckhm_pkg::H_MIX_Y: begin
        h_d   = ckhm_pkg::fnv_mix(h_q, ky_q);
        rem_d = '0;
        dig_d = '0;
      end
      ckhm_pkg::H_MOD: quo_d = prod[SH+15:SH];
      ckhm_pkg::H_RED: begin
        rem_d = (diff_lo >= 17'(BUCKETS)) ? BW'(diff_lo - 17'(BUCKETS)) : BW'(diff_lo);
        h_d   = {h_q[47:0], 16'h0000};
        dig_d = dig_q + 2'd1;
      end
      default: ;
    endcase
  end

  assign done_o   = (state_q == ckhm_pkg::H_DONE);
  assign bucket_o = POW2 ? h_q[BW-1:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ckhm_pkg::H_IDLE;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      dig_q   <= dig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    kx_q  <= kx_d;
    ky_q  <= ky_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule

### hdl/coordinate_keyed_hash_map.sv
// ----------------------------------------------------------------------------
// coordinate_keyed_hash_map
// chained hash table keyed by a signed coordinate pair: insert, lookup, remove
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// request   in         start & !busy       action_i key_x_i key_y_i new_value_i
// result    out        done_o, one cycle   ok_o found_value_o full_res_o
//
// after reset a clearing pass over max(ENTRIES, BUCKETS) addresses runs, busy high
// a request runs the hash, reads the bucket head and walks the chain entry
// by entry; remainder steps are added when BUCKETS is not a power of two
// an insert of a new key then scans used flags for a free entry and links it
// an unused action code gives its result in the cycle after acceptance
// one result per request, done_o high for one cycle; results cannot be stalled
// ----------------------------------------------------------------------------
module coordinate_keyed_hash_map #(
  parameter int ENTRIES   = 256,
  parameter int BUCKETS   = 64,
  parameter int DATA_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] key_x_i,
  input  logic [31:0] key_y_i,
  input  logic [31:0] new_value_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [31:0] found_value_o,
  output logic        full_res_o
);

  `include "coordinate_keyed_hash_map_macros.svh"

  localparam int EW    = $clog2(ENTRIES + 1);
  localparam int AW    = $clog2(ENTRIES);
  localparam int BW    = $clog2(BUCKETS);
  localparam int CLR_N = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [EW-1:0] NIL = EW'(ENTRIES);

  ckhm_pkg::ctrl_state_e state_q, state_d;

  logic [1:0]           act_q, act_d;
  logic [31:0]          kx_q, kx_d, ky_q, ky_d;
  logic [DATA_BITS-1:0] val_q, val_d;
  logic [BW-1:0]        bucket_q, bucket_d;
  logic [EW-1:0]        cur_q, cur_d, prev_q, prev_d, next_q, next_d, steps_q, steps_d;
  logic [EW-1:0]        count_q, count_d;
  logic [AW-1:0]        scan_q, scan_d;
  logic [CW-1:0]        clr_q, clr_d;
  logic                 hit_q, hit_d;
  logic                 ok_q, ok_d, full_q, full_d;
  logic [31:0]          found_q, found_d;

  logic                 hash_go, hash_done;
  logic [BW-1:0]        hash_bucket;
  logic [63:0]          val_wide, data_wide;

  // memories
  logic [EW-1:0]        head_mem [BUCKETS];
  logic [31:0]          kx_mem   [ENTRIES];
  logic [31:0]          ky_mem   [ENTRIES];
  logic [DATA_BITS-1:0] data_mem [ENTRIES];
  logic [EW-1:0]        link_mem [ENTRIES];
  logic                 used_mem [ENTRIES];

  logic [EW-1:0]        head_rd_q;
  logic [31:0]          kx_rd_q, ky_rd_q;
  logic [DATA_BITS-1:0] data_rd_q;
  logic [EW-1:0]        link_rd_q;
  logic                 used_rd_q;

  logic                 head_we, ent_we, data_we, link_we, used_we, used_wd;
  logic [BW-1:0]        head_wa;
  logic [EW-1:0]        head_wd, link_wd;
  logic [AW-1:0]        ent_wa, link_wa, used_wa;

  ckhm_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (hash_go),
    .key_x_i  (key_x_i),
    .key_y_i  (key_y_i),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  assign busy     = (state_q != ckhm_pkg::S_IDLE);
  assign hash_go  = (state_q == ckhm_pkg::S_IDLE) && start && (action_i <= ckhm_pkg::ACT_REMOVE);
  assign done_o   = (state_q == ckhm_pkg::S_DONE);
  assign ok_o          = ok_q;
  assign found_value_o = found_q;
  assign full_res_o    = full_q;

  always_comb begin
    val_wide  = {32'b0, new_value_i};
    data_wide = '0;
    data_wide[DATA_BITS-1:0] = data_rd_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ckhm_pkg::S_CLEAR: if (clr_q == CW'(CLR_N - 1)) state_d = ckhm_pkg::S_IDLE;
      ckhm_pkg::S_IDLE: begin
        if (start) state_d = hash_go ? ckhm_pkg::S_HASH : ckhm_pkg::S_DONE;
      end
      ckhm_pkg::S_HASH:  if (hash_done) state_d = ckhm_pkg::S_HEAD;
      ckhm_pkg::S_HEAD:  state_d = ckhm_pkg::S_WLOAD;
      ckhm_pkg::S_WLOAD: state_d = ckhm_pkg::S_WCHK;
      ckhm_pkg::S_WCHK: begin
        state_d = (cur_q >= NIL || steps_q == NIL) ? ckhm_pkg::S_DECIDE : ckhm_pkg::S_WRD;
      end
      ckhm_pkg::S_WRD: state_d = ckhm_pkg::S_WCMP;
      ckhm_pkg::S_WCMP: begin
        state_d = (kx_rd_q == kx_q && ky_rd_q == ky_q) ? ckhm_pkg::S_DECIDE
                                                       : ckhm_pkg::S_WCHK;
      end
      ckhm_pkg::S_DECIDE: begin
        if (act_q == ckhm_pkg::ACT_INSERT && !hit_q && count_q != NIL) begin
          state_d = ckhm_pkg::S_SCAN_RD;
        end else begin
          state_d = ckhm_pkg::S_DONE;
        end
      end
      ckhm_pkg::S_SCAN_RD: state_d = ckhm_pkg::S_SCAN_CHK;
      ckhm_pkg::S_SCAN_CHK: begin
        if (!used_rd_q) begin
          state_d = ckhm_pkg::S_NEW;
        end else if (scan_q == AW'(ENTRIES - 1)) begin
          state_d = ckhm_pkg::S_DONE;
        end else begin
          state_d = ckhm_pkg::S_SCAN_RD;
        end
      end
      ckhm_pkg::S_NEW:  state_d = ckhm_pkg::S_LINK;
      ckhm_pkg::S_LINK: state_d = ckhm_pkg::S_DONE;
      ckhm_pkg::S_DONE: state_d = ckhm_pkg::S_IDLE;
      default:          state_d = ckhm_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    act_d    = act_q;
    kx_d     = kx_q;
    ky_d     = ky_q;
    val_d    = val_q;
    bucket_d = bucket_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    next_d   = next_q;
    steps_d  = steps_q;
    count_d  = count_q;
    scan_d   = scan_q;
    clr_d    = clr_q;
    hit_d    = hit_q;
    ok_d     = ok_q;
    full_d   = full_q;
    found_d  = found_q;
    head_we  = 1'b0;
    head_wa  = bucket_q;
    head_wd  = NIL;
    ent_we   = 1'b0;
    data_we  = 1'b0;
    ent_wa   = cur_q[AW-1:0];
    link_we  = 1'b0;
    link_wa  = prev_q[AW-1:0];
    link_wd  = next_q;
    used_we  = 1'b0;
    used_wa  = cur_q[AW-1:0];
    used_wd  = 1'b0;
    case (state_q)
      ckhm_pkg::S_CLEAR: begin
        clr_d   = clr_q + CW'(1);
        head_we = ({1'b0, clr_q} < (CW+1)'(BUCKETS));
        head_wa = clr_q[BW-1:0];
        used_we = ({1'b0, clr_q} < (CW+1)'(ENTRIES));
        used_wa = clr_q[AW-1:0];
      end
      ckhm_pkg::S_IDLE: begin
        if (start) begin
          act_d   = action_i;
          kx_d    = key_x_i;
          ky_d    = key_y_i;
          val_d   = val_wide[DATA_BITS-1:0];
          ok_d    = 1'b0;
          full_d  = 1'b0;
          found_d = '0;
          hit_d   = 1'b0;
        end
      end
      ckhm_pkg::S_HASH: if (hash_done) bucket_d = hash_bucket;
      ckhm_pkg::S_WLOAD: begin
        cur_d   = head_rd_q;
        prev_d  = NIL;
        steps_d = '0;
      end
      ckhm_pkg::S_WCMP: begin
        if (kx_rd_q == kx_q && ky_rd_q == ky_q) begin
          hit_d   = 1'b1;
          next_d  = link_rd_q;
          found_d = data_wide[31:0];
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rd_q;
          steps_d = steps_q + EW'(1);
        end
      end
      ckhm_pkg::S_DECIDE: begin
        case (act_q)
          ckhm_pkg::ACT_INSERT: begin
            if (hit_q) begin
              data_we = 1'b1;
            end else if (count_q == NIL) begin
              full_d = 1'b1;
            end
            found_d = '0;
            scan_d  = '0;
          end
          ckhm_pkg::ACT_LOOKUP: ok_d = hit_q;
          ckhm_pkg::ACT_REMOVE: begin
            found_d = '0;
            if (hit_q) begin
              ok_d    = 1'b1;
              link_we = (prev_q < NIL);
              head_we = (prev_q >= NIL);
              head_wd = next_q;
              used_we = 1'b1;
              count_d = (count_q != '0) ? count_q - EW'(1) : count_q;
            end
          end
          default: ;
        endcase
      end
      ckhm_pkg::S_SCAN_CHK: begin
        if (used_rd_q) begin
          if (scan_q == AW'(ENTRIES - 1)) full_d = 1'b1;
          else scan_d = scan_q + AW'(1);
        end
      end
      ckhm_pkg::S_NEW: begin
        ent_we  = 1'b1;
        data_we = 1'b1;
        ent_wa  = scan_q;
        link_we = 1'b1;
        link_wa = scan_q;
        link_wd = NIL;
        used_we = 1'b1;
        used_wa = scan_q;
        used_wd = 1'b1;
        count_d = count_q + EW'(1);
        ok_d    = 1'b1;
      end
      ckhm_pkg::S_LINK: begin
        link_we = (prev_q < NIL);
        link_wa = prev_q[AW-1:0];
        link_wd = EW'(scan_q);
        head_we = (prev_q >= NIL);
        head_wd = EW'(scan_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ckhm_pkg::S_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    kx_q     <= kx_d;
    ky_q     <= ky_d;
    val_q    <= val_d;
    bucket_q <= bucket_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    next_q   <= next_d;
    steps_q  <= steps_d;
    scan_q   <= scan_d;
    hit_q    <= hit_d;
    ok_q     <= ok_d;
    full_q   <= full_d;
    found_q  <= found_d;
  end

  // bucket heads
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[bucket_q];
  end

  // entry fields
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      kx_mem[ent_wa] <= kx_q;
      ky_mem[ent_wa] <= ky_q;
    end
    if (data_we) data_mem[ent_wa] <= val_q;
    kx_rd_q   <= kx_mem[cur_q[AW-1:0]];
    ky_rd_q   <= ky_mem[cur_q[AW-1:0]];
    data_rd_q <= data_mem[cur_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_q <= link_mem[cur_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_rd_q <= used_mem[scan_q];
  end

  `CKHM_ASSERT_IMP(a_ok_full_excl, clk_i, rst_ni, done_o, !(ok_o && full_res_o), "ok and full together")
  `CKHM_ASSERT_IMP(a_found_needs_ok, clk_i, rst_ni, done_o && found_value_o != 32'd0, ok_o, "value without hit")
  `CKHM_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "request accepted but not busy")
  `CKHM_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= NIL, "entry count overflow")

endmodule
